// ===== hw/rtl/dspm_pkg.sv =====
// Shared types and constants for the dot-star pattern matcher.
// No dependencies; imported by every module of the block except dspm_ram.
`timescale 1ns / 1ps

package dspm_pkg;

  localparam int unsigned PatternMaxDef = 32;

  localparam logic [7:0] CharStar = 8'h2A;
  localparam logic [7:0] CharDot  = 8'h2E;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TEXT = 2'd1,
    OP_END  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_STEP,
    ST_FINISH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       start;
    logic       step;
    logic       first;
    logic       finish;
    logic       init;
    logic [7:0] ch;
  } ctl_t;

endpackage

// ===== hw/rtl/dspm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dspm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dspm_row_unit.sv =====
// Shared match-bit update unit: holds the match row as a shift register and
// computes one row bit per step from the pattern byte stream. Uses dspm_pkg.
`timescale 1ns / 1ps

module dspm_row_unit
  import dspm_pkg::*;
#(
  parameter int unsigned PatternMax = PatternMaxDef,
  localparam int unsigned Rw = PatternMax + 1,
  localparam int unsigned Cw = $clog2(PatternMax + 1)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctl_t       ctl_i,
  input  logic [7:0] pat_i,
  input  logic [5:0] len_i,
  output logic       match_o
);

  logic [Rw-1:0] row_q, row_d;
  logic          nm1_q, nm1_d;
  logic          nm2_q, nm2_d;
  logic [7:0]    prev_q, prev_d;
  logic          bit_new;
  logic          hit_prev;
  logic [6:0]    len_ext;
  logic [6:0]    len_sat;
  logic [Cw-1:0] len_idx;

  always_comb begin
    hit_prev = (ctl_i.ch == prev_q) || (prev_q == CharDot);
    bit_new  = 1'b0;
    if (ctl_i.init) begin
      bit_new = !ctl_i.first && nm2_q && (pat_i == CharStar);
    end else if (pat_i == CharStar) begin
      bit_new = !ctl_i.first && (nm2_q || (row_q[1] && hit_prev));
    end else if ((ctl_i.ch == pat_i) || (pat_i == CharDot)) begin
      bit_new = row_q[0];
    end
  end

  always_comb begin
    row_d  = row_q;
    nm1_d  = nm1_q;
    nm2_d  = nm2_q;
    prev_d = prev_q;
    if (ctl_i.start) begin
      nm1_d = ctl_i.init;
      nm2_d = 1'b0;
    end
    if (ctl_i.step) begin
      row_d  = {bit_new, row_q[Rw-1:1]};
      nm2_d  = nm1_q;
      nm1_d  = bit_new;
      prev_d = pat_i;
    end
    if (ctl_i.finish) begin
      row_d[0] = ctl_i.init;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nm1_q  <= nm1_d;
    nm2_q  <= nm2_d;
    prev_q <= prev_d;
  end

  assign len_ext = {1'b0, len_i};
  assign len_sat = (len_ext > 7'(PatternMax)) ? 7'(PatternMax) : len_ext;
  assign len_idx = len_sat[Cw-1:0];
  assign match_o = row_q[len_idx];

endmodule

// ===== hw/rtl/dspm_seq.sv =====
// Sequencer: takes input beats, walks the pattern positions, drives the row
// unit and the pattern store, and holds the result beat. Uses dspm_pkg.
`timescale 1ns / 1ps

module dspm_seq
  import dspm_pkg::*;
#(
  parameter int unsigned PatternMax = PatternMaxDef,
  localparam int unsigned Aw = (PatternMax > 1) ? $clog2(PatternMax) : 1,
  localparam int unsigned Cw = $clog2(PatternMax + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    in_op_i,
  input  logic [4:0]    in_pos_i,
  input  logic [7:0]    in_ch_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          out_bit_o,
  output logic          ram_we_o,
  output logic [Aw-1:0] ram_waddr_o,
  output logic [Aw-1:0] ram_raddr_o,
  output ctl_t          ctl_o,
  input  logic          match_i
);

  state_e        state_q, state_d;
  logic [Cw-1:0] cnt_q, cnt_d;
  logic          init_q, init_d;
  logic          is_end_q, is_end_d;
  logic          fresh_q, fresh_d;
  logic [7:0]    ch_q, ch_d;
  logic          out_valid_q, out_valid_d;
  logic          out_bit_q, out_bit_d;
  logic          accept;
  logic          out_free;
  logic [6:0]    pos_ext;
  op_e           op;

  assign op       = op_e'(in_op_i);
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;
  assign pos_ext  = {2'b0, in_pos_i};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_TEXT: state_d = ST_ISSUE;
            OP_END:  state_d = fresh_q ? ST_ISSUE : ST_EMIT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ISSUE:  state_d = ST_STEP;
      ST_STEP:   state_d = (cnt_q == Cw'(PatternMax)) ? ST_FINISH : ST_STEP;
      ST_FINISH: begin
        if (is_end_q) begin
          state_d = ST_EMIT;
        end else if (init_q) begin
          state_d = ST_ISSUE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT:   state_d = out_free ? ST_IDLE : ST_EMIT;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    init_d      = init_q;
    is_end_d    = is_end_q;
    fresh_d     = fresh_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_bit_d   = out_bit_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_TEXT: begin
              ch_d     = in_ch_i;
              is_end_d = 1'b0;
              init_d   = fresh_q;
              fresh_d  = 1'b0;
            end
            OP_END: begin
              is_end_d = 1'b1;
              init_d   = fresh_q;
              fresh_d  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE:  cnt_d = Cw'(1);
      ST_STEP:   cnt_d = cnt_q + Cw'(1);
      ST_FINISH: begin
        if (!is_end_q) begin
          init_d = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_bit_d   = match_i;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    ram_we_o    = accept && (op == OP_LOAD) && (pos_ext < 7'(PatternMax));
    ram_waddr_o = pos_ext[Aw-1:0];
    ram_raddr_o = '0;
    ctl_o       = '0;
    ctl_o.init  = init_q;
    ctl_o.ch    = ch_q;
    case (state_q)
      ST_ISSUE:  ctl_o.start = 1'b1;
      ST_STEP: begin
        ctl_o.step  = 1'b1;
        ctl_o.first = (cnt_q == Cw'(1));
        ram_raddr_o = cnt_q[Aw-1:0];
      end
      ST_FINISH: ctl_o.finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      init_q      <= 1'b0;
      is_end_q    <= 1'b0;
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      init_q      <= init_d;
      is_end_q    <= is_end_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q      <= ch_d;
    out_bit_q <= out_bit_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_bit_o   = out_bit_q;

endmodule

// ===== hw/rtl/dot_star_pattern_matcher_core.sv =====
// Top level of the dot-star pattern matcher: pattern store, sequencer and
// row update unit. Uses dspm_pkg, dspm_ram, dspm_seq, dspm_row_unit.
//
//   Channel   Dir  Beat contents
//   s_axis    in   tuser: operation; tdata: position [4:0], character [12:5]
//   m_axis    out  tdata: matched [0]
//   cfg       in   cfg_data_i: pattern_length
//
// Load beat: written to the pattern store as it is taken. Text beat: a walk over
// the pattern positions, one pattern position per cycle through the row unit; the
// first text beat after reset or an end beat adds a walk to build the initial row.
// End beat: goes to the emit step, after the initial-row walk when no text came before it.
// The result beat is held in an output register; input beats are taken while it waits,
// and a second end beat holds in its emit step until the register frees.
// Reset clears the control state and the match row; the pattern store is not cleared.
`timescale 1ns / 1ps

module dot_star_pattern_matcher_core
  import dspm_pkg::*;
#(
  parameter int unsigned PatternMax = PatternMaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // position [4:0], character [12:5], zero [15:13]
  input  logic [1:0]  s_axis_tuser,  // operation [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // matched [0], zero [7:1]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i
);

  localparam int unsigned Aw = (PatternMax > 1) ? $clog2(PatternMax) : 1;

  logic [5:0]    len_q;
  logic          ram_we;
  logic [Aw-1:0] ram_waddr;
  logic [Aw-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  ctl_t          ctl;
  logic          match;
  logic          out_bit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_valid_i) begin
      len_q <= cfg_data_i;
    end
  end

  dspm_ram #(
    .Width (8),
    .Depth (PatternMax)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata[12:5]),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dspm_seq #(
    .PatternMax (PatternMax)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_pos_i    (s_axis_tdata[4:0]),
    .in_ch_i     (s_axis_tdata[12:5]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_bit_o   (out_bit),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_raddr_o (ram_raddr),
    .ctl_o       (ctl),
    .match_i     (match)
  );

  dspm_row_unit #(
    .PatternMax (PatternMax)
  ) u_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .pat_i   (ram_rdata),
    .len_i   (len_q),
    .match_o (match)
  );

  assign m_axis_tdata = {7'b0, out_bit};

endmodule

// ===== hw/rtl/dspm_checker.sv =====
// Port-level checks for the dot-star pattern matcher, bound to the top level.
// Uses dspm_pkg.
`timescale 1ns / 1ps

module dspm_checker
  import dspm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  a_text_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser == OP_TEXT) |=> !s_axis_tready)
    else $error("ready right after a text beat");

  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser == OP_END) |=> !s_axis_tready)
    else $error("ready right after an end beat");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'b0))
    else $error("result padding bits not zero");

endmodule

bind dot_star_pattern_matcher_core dspm_checker u_dspm_checker (.*);
